// ===== design/bldiff_pkg.sv =====
// ----------------------------------------------------------------------------
// bldiff_pkg
// Shared types, codes and helpers for the book level diff engine.
// ----------------------------------------------------------------------------
package bldiff_pkg;

	// default number of levels kept per side
	localparam int BOOK_DEPTH_DEF = 16;

	// width of one stored level: price over quantity
	localparam int ENTRY_W = 64;

	// configuration port address width and register index
	localparam int PADDR_W = 3;
	localparam logic REG_SYMBOL_CODE = 1'b0;

	// input command codes
	localparam logic CMD_LEVEL = 1'b0;
	localparam logic CMD_END   = 1'b1;

	// side codes
	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	// result kind codes
	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_REDUCE = 1'b1;

	// one input item
	typedef struct packed {
		logic        command;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
	} in_t;

	// one result item
	typedef struct packed {
		logic [31:0] symbol;
		logic        out_side;
		logic        kind;
		logic [31:0] level_price;
		logic [31:0] amount;
		logic        last;
	} out_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // latch the accepted item
		logic red;     // reduce the mirror level under the cursor, advance
		logic lvl;     // final step of a level: match or add, stage it
		logic fin;     // final merge step of this item; only a close or copy may follow
		logic copy;    // move one staged level into the mirror
		logic commit;  // new list becomes the mirror of its side
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic drop;       // item at the ports is to be ignored
		logic in_end;     // item at the ports is an end marker
		logic item_end;   // latched item is an end marker
		logic cur_lt;     // cursor still inside the mirror
		logic cur_last;   // cursor sits on the last mirror level
		logic mir_ahead;  // mirror level comes before the new level
		logic lvl_emit;   // final level step produces a command
		logic pend_v;     // a command waits in the hold register
		logic copy_more;  // staged levels left to copy
	} dp_status_t;

	// true when price a ranks before price b on side s
	function automatic logic ahead(input logic s, input logic [31:0] a,
			input logic [31:0] b);
		logic r;
		if (s == SIDE_BID) begin
			r = a > b;
		end else begin
			r = a < b;
		end
		return r;
	endfunction

endpackage

// ===== design/bldiff_ram.sv =====
// ----------------------------------------------------------------------------
// bldiff_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bldiff_ram #(
	parameter int WIDTH = bldiff_pkg::ENTRY_W,
	parameter int DEPTH = bldiff_pkg::BOOK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ===== design/bldiff_dp.sv =====
// ----------------------------------------------------------------------------
// bldiff_dp
// Datapath: mirror and staging memories, cursor, merge compare and the
// result hold and output registers.
// ----------------------------------------------------------------------------
module bldiff_dp #(
	parameter int BOOK_DEPTH = bldiff_pkg::BOOK_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bldiff_pkg::ctrl_cmd_t  cmd,
	output bldiff_pkg::dp_status_t status,
	input  bldiff_pkg::in_t        item,
	input  logic [31:0]            symbol_code,
	output bldiff_pkg::out_t       result,
	output logic                   result_stb
);

	localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
	localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int ROWS  = 2 ** IDX_W;

	// item and merge state
	bldiff_pkg::in_t  item_q;
	logic [CNT_W-1:0] cursor_q;
	logic [CNT_W-1:0] scount_q;
	logic [CNT_W-1:0] ci_q;
	logic [31:0]      prev_q;
	logic             list_open_q;
	logic             list_side_q;
	logic [CNT_W-1:0] mcount_q [2];

	// hold and output registers
	logic             pend_v_q;
	bldiff_pkg::out_t pend_q;
	bldiff_pkg::out_t res_q;
	logic             res_stb_q;

	// memory ports
	logic [bldiff_pkg::ENTRY_W-1:0] mir_rd;
	logic [bldiff_pkg::ENTRY_W-1:0] stg_rd;
	logic [IDX_W:0]                 mir_raddr;
	logic [IDX_W:0]                 mir_waddr;
	logic [IDX_W-1:0]               stg_raddr;

	// next-value and compare signals
	logic             side_d;
	logic [CNT_W-1:0] cursor_d;
	logic [CNT_W-1:0] ci_d;
	logic [CNT_W-1:0] cnt;
	logic [31:0]      mp;
	logic [31:0]      mq;
	logic             match;
	logic             qty_gt;
	logic [31:0]      diff;
	logic             lvl_emit;
	logic             push;
	bldiff_pkg::out_t new_cmd;
	logic             emit;
	bldiff_pkg::out_t emit_cmd;
	logic             other_side;
	logic             lvl_bad;

	// drop check on the item at the ports
	assign other_side = list_open_q && (item.side != list_side_q);
	assign lvl_bad = (item.command == bldiff_pkg::CMD_LEVEL) &&
		((item.qty == 32'd0) || (scount_q >= CNT_W'(BOOK_DEPTH)) ||
		 ((scount_q != '0) && !bldiff_pkg::ahead(item.side, prev_q, item.price)));

	// mirror level under the cursor
	assign cnt = mcount_q[item_q.side];
	assign mp  = mir_rd[63:32];
	assign mq  = mir_rd[31:0];

	// merge compare
	assign match    = (cursor_q < cnt) && (mp == item_q.price);
	assign qty_gt   = item_q.qty > mq;
	assign diff     = qty_gt ? (item_q.qty - mq) : (mq - item_q.qty);
	assign lvl_emit = !match || (item_q.qty != mq);
	assign push     = cmd.red || (cmd.lvl && lvl_emit);

	// status to the controller
	always_comb begin
		status.drop      = other_side || lvl_bad;
		status.in_end    = item.command == bldiff_pkg::CMD_END;
		status.item_end  = item_q.command == bldiff_pkg::CMD_END;
		status.cur_lt    = cursor_q < cnt;
		status.cur_last  = ({1'b0, cursor_q} + 1'b1) == {1'b0, cnt};
		status.mir_ahead = (cursor_q < cnt) &&
			bldiff_pkg::ahead(item_q.side, mp, item_q.price);
		status.lvl_emit  = lvl_emit;
		status.pend_v    = pend_v_q;
		status.copy_more = ci_q < scount_q;
	end

	// command formed this cycle
	always_comb begin
		new_cmd.symbol   = symbol_code;
		new_cmd.out_side = item_q.side;
		new_cmd.last     = 1'b0;
		if (cmd.red) begin
			new_cmd.kind        = bldiff_pkg::KIND_REDUCE;
			new_cmd.level_price = mp;
			new_cmd.amount      = mq;
		end else if (match) begin
			new_cmd.kind        = qty_gt ? bldiff_pkg::KIND_ADD : bldiff_pkg::KIND_REDUCE;
			new_cmd.level_price = item_q.price;
			new_cmd.amount      = diff;
		end else begin
			new_cmd.kind        = bldiff_pkg::KIND_ADD;
			new_cmd.level_price = item_q.price;
			new_cmd.amount      = item_q.qty;
		end
	end

	// the held command goes out once the next one, or the end, is known
	always_comb begin
		if (pend_v_q) begin
			emit          = push || cmd.fin;
			emit_cmd      = pend_q;
			emit_cmd.last = cmd.fin && !push;
		end else begin
			emit          = cmd.fin && push;
			emit_cmd      = new_cmd;
			emit_cmd.last = 1'b1;
		end
	end

	// memory addressing follows the next cursor and copy index
	always_comb begin
		side_d = cmd.load ? item.side : item_q.side;
		if (cmd.commit) begin
			cursor_d = '0;
		end else if (cmd.red || (cmd.lvl && match)) begin
			cursor_d = cursor_q + 1'b1;
		end else begin
			cursor_d = cursor_q;
		end
		if (cmd.commit) begin
			ci_d = '0;
		end else if (cmd.copy) begin
			ci_d = ci_q + 1'b1;
		end else begin
			ci_d = ci_q;
		end
	end

	assign mir_raddr = {side_d, cursor_d[IDX_W-1:0]};
	assign mir_waddr = {item_q.side, ci_q[IDX_W-1:0]};
	assign stg_raddr = ci_d[IDX_W-1:0];

	// mirror levels, both sides
	bldiff_ram #(
		.WIDTH(bldiff_pkg::ENTRY_W),
		.DEPTH(2 * ROWS)
	) u_mirror (
		.clk  (clk),
		.we   (cmd.copy),
		.waddr(mir_waddr),
		.wdata(stg_rd),
		.raddr(mir_raddr),
		.rdata(mir_rd)
	);

	// list in progress
	bldiff_ram #(
		.WIDTH(bldiff_pkg::ENTRY_W),
		.DEPTH(ROWS)
	) u_staged (
		.clk  (clk),
		.we   (cmd.lvl),
		.waddr(scount_q[IDX_W-1:0]),
		.wdata({item_q.price, item_q.qty}),
		.raddr(stg_raddr),
		.rdata(stg_rd)
	);

	// merge state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			scount_q    <= '0;
			ci_q        <= '0;
			prev_q      <= '0;
			list_open_q <= 1'b0;
			list_side_q <= bldiff_pkg::SIDE_BID;
			mcount_q[0] <= '0;
			mcount_q[1] <= '0;
		end else begin
			cursor_q <= cursor_d;
			ci_q     <= ci_d;
			if (cmd.lvl) begin
				scount_q    <= scount_q + 1'b1;
				prev_q      <= item_q.price;
				list_open_q <= 1'b1;
				list_side_q <= item_q.side;
			end
			if (cmd.commit) begin
				mcount_q[item_q.side] <= scount_q;
				scount_q    <= '0;
				prev_q      <= '0;
				list_open_q <= 1'b0;
				list_side_q <= bldiff_pkg::SIDE_BID;
			end
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// hold register valid and output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q  <= 1'b0;
			res_stb_q <= 1'b0;
		end else begin
			res_stb_q <= emit;
			if (push && !(cmd.fin && !pend_v_q)) begin
				pend_v_q <= 1'b1;
			end else if (cmd.fin) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// hold and output payload
	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= new_cmd;
		end
		if (emit) begin
			res_q <= emit_cmd;
		end
	end

	assign result     = res_q;
	assign result_stb = res_stb_q;

	// cursor never passes the end of the mirror of the open list
	assert property (@(posedge clk) disable iff (!arst_n)
		list_open_q |-> (cursor_q <= mcount_q[list_side_q]))
		else $error("cursor beyond mirror of open list");

	// nothing follows the last command in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_stb && result.last) |=> !result_stb)
		else $error("result right after last");

	// staged list never exceeds the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		scount_q <= CNT_W'(BOOK_DEPTH))
		else $error("staged count beyond depth");

endmodule

// ===== design/bldiff_ctrl.sv =====
// ----------------------------------------------------------------------------
// bldiff_ctrl
// Controller: sequences the merge of one level, the flush at the end
// marker and the copy of the staged list into the mirror.
// ----------------------------------------------------------------------------
module bldiff_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  bldiff_pkg::dp_status_t status,
	output bldiff_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEVEL,
		S_FLUSH,
		S_CLOSE,
		S_COPY
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	// commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				// the end-marker decision is taken on the item at the ports
				if (start && !status.drop) begin
					state_d = status.in_end ? S_FLUSH : S_LEVEL;
				end
			end
			S_LEVEL: begin
				if (status.mir_ahead) begin
					cmd.red = 1'b1;
				end else begin
					cmd.lvl = 1'b1;
					cmd.fin = 1'b1;
					state_d = (status.pend_v && status.lvl_emit) ? S_CLOSE : S_IDLE;
				end
			end
			S_FLUSH: begin
				if (status.cur_lt) begin
					cmd.red = 1'b1;
					cmd.fin = status.cur_last;
					if (status.cur_last) begin
						state_d = status.pend_v ? S_CLOSE : S_COPY;
					end
				end else begin
					cmd.fin = 1'b1;
					state_d = S_COPY;
				end
			end
			S_CLOSE: begin
				cmd.fin = 1'b1;
				state_d = status.item_end ? S_COPY : S_IDLE;
			end
			S_COPY: begin
				if (status.copy_more) begin
					cmd.copy = 1'b1;
				end else begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= state_d != S_IDLE;
		end
	end

	assign busy = busy_q;

	// no command is held between items
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !status.pend_v)
		else $error("held command while idle");

	// busy tracks the state machine
	assert property (@(posedge clk) disable iff (!arst_n)
		busy == (state_q != S_IDLE))
		else $error("busy out of step with state");

endmodule

// ===== design/book_level_diff_engine_top.sv =====
// ----------------------------------------------------------------------------
// book_level_diff_engine_top
// Order book level mirror with streaming merge diff, bid and ask sides.
//
//   channel  handshake                      payload
//   input    start && !busy                 item   (command, side, price, qty)
//   result   result_stb, one cycle          result (symbol .. last)
//   config   psel && penable && pwrite      pwdata at paddr, prdata on read
//
// A level reduces each mirror level that ranks ahead of it, then is matched
// or added, with a close step when a reduce is still held as the final
// command is formed; the mirror memory gives one level per cycle to the
// compare. An end marker flushes the remaining mirror levels, then copies
// the staged list in. Reset empties both sides with no clearing pass.
// Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module book_level_diff_engine_top #(
	parameter int BOOK_DEPTH = bldiff_pkg::BOOK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  bldiff_pkg::in_t                item,
	output logic                           busy,
	output bldiff_pkg::out_t               result,
	output logic                           result_stb,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bldiff_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	logic [31:0]           symbol_q;
	bldiff_pkg::ctrl_cmd_t cmd;
	bldiff_pkg::dp_status_t status;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_q <= '0;
		end else if (psel && penable && pwrite &&
				paddr[bldiff_pkg::PADDR_W-1] == bldiff_pkg::REG_SYMBOL_CODE) begin
			symbol_q <= pwdata;
		end
	end

	// read back
	assign prdata = (paddr[bldiff_pkg::PADDR_W-1] == bldiff_pkg::REG_SYMBOL_CODE) ?
		symbol_q : 32'd0;
	assign pready = 1'b1;

	bldiff_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.status(status),
		.cmd   (cmd)
	);

	bldiff_dp #(
		.BOOK_DEPTH(BOOK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.item       (item),
		.symbol_code(symbol_q),
		.result     (result),
		.result_stb (result_stb)
	);

endmodule
